>>> rtl/core/b2da_pkg.sv
package b2da_pkg;

  // Width of one packed BCD digit.
  localparam int DIGIT_W = 4;

  // ASCII code of '0', trimmed to the 6-bit character field.
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // Double-dabble threshold and correction.
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

  // Converter sequencer states.
  typedef enum logic [1:0] {
    DBL_IDLE,
    DBL_SHIFT,
    DBL_HOLD
  } dbl_state_t;

endpackage

>>> rtl/core/binary_to_decimal_ascii.sv
// Flow: a value is loaded and shifted into the BCD register one bit per shift step.
// The BCD word is then held for handoff to the emitter, which skips leading zeros
// and registers each remaining digit in the output register.
// The dabble loop takes a new value only after the emitter has taken the previous
// BCD word, and a busy emitter holds that handoff; digit emission overlaps the next conversion.
// Reset: synchronous active-low rst_n empties both stages and the output register.
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int MAX_DIGITS = 20,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input item stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] binary_value
  // Result item stream, one item per decimal digit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic        out_tlast   // last_digit
);

  localparam int BCD_W = DIGIT_W * MAX_DIGITS;

  logic             bcd_valid;
  logic             bcd_take;
  logic [BCD_W-1:0] bcd;
  logic [5:0]       digit_char;

  // Bit-serial double dabble: one value bit enters the BCD register per cycle.
  // Bits above VALUE_BITS are ignored; decimal digits beyond MAX_DIGITS fall
  // off the top of the BCD register.
  b2da_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dabble (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_tvalid),
    .load_value (in_tdata[VALUE_BITS-1:0]),
    .load_ready (in_tready),
    .bcd_valid  (bcd_valid),
    .bcd_take   (bcd_take),
    .bcd        (bcd)
  );

  // Digit-serial emitter: shift the BCD word out one digit per cycle while the output is free, most
  // significant first, dropping leading zeros but always keeping the last digit.
  b2da_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .bcd_valid (bcd_valid),
    .bcd       (bcd),
    .bcd_take  (bcd_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (digit_char),
    .out_last  (out_tlast)
  );

  // Pad the 6-bit character up to a whole byte.
  assign out_tdata = {2'b00, digit_char};

endmodule

>>> rtl/core/b2da_dabble.sv
module b2da_dabble
  import b2da_pkg::*;
#(
  parameter int VALUE_BITS = 64,
  parameter int MAX_DIGITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load_valid,
  input  logic [VALUE_BITS-1:0]         load_value,
  output logic                          load_ready,
  output logic                          bcd_valid,
  input  logic                          bcd_take,
  output logic [DIGIT_W*MAX_DIGITS-1:0] bcd
);

  localparam int BCD_W = DIGIT_W * MAX_DIGITS;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  dbl_state_t             state_r, state_nxt;
  logic [VALUE_BITS-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [BCD_W-1:0]       adj;

  // Add 3 to every digit of five or more; digits are independent.
  always_comb begin
    logic [DIGIT_W-1:0] d;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      d = bcd_r[DIGIT_W*i +: DIGIT_W];
      adj[DIGIT_W*i +: DIGIT_W] = (d >= DABBLE_LIMIT) ? d + DABBLE_ADD : d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DBL_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    bin_nxt    = bin_r;
    bcd_nxt    = bcd_r;
    cnt_nxt    = cnt_r;
    load_ready = 1'b0;
    bcd_valid  = 1'b0;
    unique case (state_r)
      DBL_IDLE: begin
        load_ready = 1'b1;
        if (load_valid) begin
          bin_nxt   = load_value;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_BITS);
          state_nxt = DBL_SHIFT;
        end
      end
      DBL_SHIFT: begin
        // Shift one value bit into the adjusted BCD register.
        bin_nxt = bin_r << 1;
        bcd_nxt = {adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = DBL_HOLD;
        end
      end
      DBL_HOLD: begin
        bcd_valid = 1'b1;
        if (bcd_take) begin
          state_nxt = DBL_IDLE;
        end
      end
      default: state_nxt = DBL_IDLE;
    endcase
  end

  assign bcd = bcd_r;

endmodule

>>> rtl/core/b2da_emit.sv
module b2da_emit
  import b2da_pkg::*;
#(
  parameter int MAX_DIGITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          bcd_valid,
  input  logic [DIGIT_W*MAX_DIGITS-1:0] bcd,
  output logic                          bcd_take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [5:0]                    out_char,
  output logic                          out_last
);

  localparam int BCD_W = DIGIT_W * MAX_DIGITS;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [BCD_W-1:0]   dig_r, dig_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               started_r, started_nxt;
  logic               oval_r, oval_nxt;
  logic [5:0]         ochar_r, ochar_nxt;
  logic               olast_r, olast_nxt;
  logic [DIGIT_W-1:0] top;
  logic               out_free;

  assign top      = dig_r[BCD_W-1 -: DIGIT_W];
  assign out_free = !oval_r || out_ready;
  assign bcd_take = bcd_valid && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      started_r <= 1'b0;
      oval_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      busy_r    <= busy_nxt;
      started_r <= started_nxt;
      oval_r    <= oval_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r   <= dig_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    dig_nxt     = dig_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    started_nxt = started_r;
    oval_nxt    = oval_r && !out_ready;
    ochar_nxt   = ochar_r;
    olast_nxt   = olast_r;
    if (bcd_take) begin
      dig_nxt     = bcd;
      cnt_nxt     = CNT_W'(MAX_DIGITS);
      busy_nxt    = 1'b1;
      started_nxt = 1'b0;
    end else if (busy_r) begin
      if (!started_r && top == '0 && cnt_r > CNT_W'(1)) begin
        // Drop a leading zero digit.
        dig_nxt = dig_r << DIGIT_W;
        cnt_nxt = cnt_r - 1'b1;
      end else if (out_free) begin
        oval_nxt    = 1'b1;
        ochar_nxt   = ASCII_ZERO + {2'b00, top};
        olast_nxt   = (cnt_r == CNT_W'(1));
        dig_nxt     = dig_r << DIGIT_W;
        cnt_nxt     = cnt_r - 1'b1;
        started_nxt = 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  assign out_valid = oval_r;
  assign out_char  = ochar_r;
  assign out_last  = olast_r;

endmodule
